### hdl/adsr_pkg.sv
`timescale 1ns / 1ps
package adsr_pkg;

   localparam int NumChannelsDefault = 4;
   localparam logic [23:0] LevelOne = 24'h800000;
   localparam logic [11:0] KnobFull = 12'd4095;
   localparam logic [15:0] StepsFull = 16'd48000;
   localparam logic [23:0] KnobSquare = 24'd16769025;
   localparam int DivNumWidth = 48;
   localparam int DivDenWidth = 40;

   // Register indexes on the configuration port.
   localparam logic [2:0] CsrAttack = 3'd0;
   localparam logic [2:0] CsrDecay = 3'd1;
   localparam logic [2:0] CsrSustain = 3'd2;
   localparam logic [2:0] CsrRelease = 3'd3;
   localparam logic [2:0] CsrAmplitude = 3'd4;

   localparam logic OpGate = 1'b0;
   localparam logic OpAudio = 1'b1;

   typedef struct packed {
      logic [11:0] attack;
      logic [11:0] decay;
      logic [11:0] sustain;
      logic [11:0] release_k;
      logic [2:0]  amp_sel;
   } cfg_type;

   typedef struct packed {
      logic        opcode;
      logic [7:0]  header;
      logic [23:0] payload;
   } item_type;

   // Divisor of the envelope output for each amplitude select code.
   function automatic logic [5:0] amp_divisor(input logic [2:0] sel);
      logic [5:0] d;
      case (sel)
         3'd0: d = 6'd1;
         3'd1: d = 6'd2;
         3'd2: d = 6'd6;
         3'd3: d = 6'd16;
         default: d = 6'd32;
      endcase
      return d;
   endfunction

endpackage

### hdl/adsr_front.sv
`timescale 1ns / 1ps
module adsr_front
   import adsr_pkg::*;
#(
   parameter int NUM_CHANNELS = NumChannelsDefault
) (
   input  logic        req_valid,
   input  logic        queue_full,
   input  logic        req_opcode,
   input  logic [7:0]  req_frame_header,
   input  logic [23:0] req_frame_payload,
   output logic        req_ready,
   output logic        push,
   output item_type    push_item
);

   logic hdr_ok;

   // A frame is kept only when its header nibble and channel are valid.
   always_comb begin
      hdr_ok = (req_frame_header[3:0] == 4'hF) &&
               ({1'b0, req_frame_header[6:4]} < 4'(NUM_CHANNELS));
      req_ready = !queue_full;
      push = req_valid && !queue_full && hdr_ok;
      push_item.opcode = req_opcode;
      push_item.header = req_frame_header;
      push_item.payload = req_frame_payload;
   end

endmodule

### hdl/adsr_queue.sv
`timescale 1ns / 1ps
module adsr_queue
   import adsr_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   input  logic     pop,
   output logic     full,
   output logic     not_empty,
   output item_type head
);

   item_type slot_ff [2];
   logic     wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] count_ff, count_in;

   always_comb begin
      full = (count_ff == 2'd2);
      not_empty = (count_ff != 2'd0);
      head = slot_ff[rd_ff];
      wr_in = push ? !wr_ff : wr_ff;
      rd_in = pop ? !rd_ff : rd_ff;
      count_in = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= 1'b0;
         rd_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         count_ff <= count_in;
      end
      if (push) begin
         slot_ff[wr_ff] <= push_item;
      end
   end

endmodule

### hdl/adsr_div.sv
`timescale 1ns / 1ps
module adsr_div
   import adsr_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [DivNumWidth-1:0] num,
   input  logic [DivDenWidth-1:0] den,
   output logic                   done,
   output logic [DivNumWidth-1:0] quo
);

   logic [DivDenWidth-1:0] rem_ff, rem_in, den_ff;
   logic [DivNumWidth-1:0] quo_ff, quo_in;
   logic [5:0]             cnt_ff, cnt_in;
   logic                   done_ff, done_in;
   logic [DivDenWidth:0]   trial;

   // One quotient bit per cycle, restoring form.
   always_comb begin
      trial = {rem_ff, quo_ff[DivNumWidth-1]};
      rem_in = rem_ff;
      quo_in = quo_ff;
      cnt_in = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = '0;
         quo_in = num;
         cnt_in = 6'(DivNumWidth);
      end else if (cnt_ff != 6'd0) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = DivDenWidth'(trial - {1'b0, den_ff});
            quo_in = {quo_ff[DivNumWidth-2:0], 1'b1};
         end else begin
            rem_in = trial[DivDenWidth-1:0];
            quo_in = {quo_ff[DivNumWidth-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         done_in = (cnt_ff == 6'd1);
      end
      done = done_ff;
      quo = quo_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 6'd0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (start) begin
         den_ff <= den;
      end
   end

endmodule

### hdl/adsr_back.sv
`timescale 1ns / 1ps
module adsr_back
   import adsr_pkg::*;
#(
   parameter int NUM_CHANNELS = NumChannelsDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        item_valid,
   input  item_type    item,
   output logic        pop,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_header,
   output logic signed [23:0] rsp_shaped_sample,
   output logic [23:0] rsp_envelope_value
);

   localparam int CW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam logic [31:0] ThirdMagic = 32'hAAAAAAAB;

   typedef enum logic [2:0] {
      PH_IDLE, PH_ATTACK, PH_DECAY, PH_SUSTAIN, PH_RELEASE
   } phase_type;

   typedef enum logic [3:0] {
      S_WAIT, S_SUS, S_STEP, S_STEPW, S_UPD, S_ENV, S_ENVW, S_OUT
   } state_type;

   state_type state_ff;
   logic [23:0] level_ff [NUM_CHANNELS];
   phase_type   phase_ff [NUM_CHANNELS];
   logic        gnow_ff [NUM_CHANNELS];
   logic        gbef_ff [NUM_CHANNELS];

   logic [CW-1:0] ch_ff;
   logic [7:0]    hdr_ff;
   logic [23:0]   pay_ff;
   logic          g_ff;
   phase_type     ph_ff;
   logic [23:0]   lvl_ff, sus_ff, env_ff;
   logic [23:0]   asq_ff;
   logic [24:0]   step_ff;
   logic [48:0]   prod_ff;
   logic [24:0]   env_num_ff;
   logic          rsp_valid_ff;
   logic [7:0]    out_hdr_ff;
   logic signed [23:0] out_smp_ff;
   logic [23:0]   out_env_ff;

   logic [CW-1:0] ch_sel;
   logic          div_start, div_done;
   logic [DivNumWidth-1:0] div_num, div_quo;
   logic [DivDenWidth-1:0] div_den;
   logic signed [26:0] lvl_s, step_s, sus_s, nl;
   phase_type     np;
   logic [24:0]   rel_step, mag;
   logic [47:0]   env_num;
   logic [24:0]   prod_hi;
   logic signed [23:0] smp;
   logic [23:0]   sus_y, sus_t, sus_calc;
   logic [55:0]   third_prod;
   logic [23:0]   env_q;

   adsr_div u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .num(div_num), .den(div_den), .done(div_done), .quo(div_quo)
   );

   // Operand selection for the divider, which forms the phase step.
   always_comb begin
      ch_sel = item.header[4+CW-1:4];
      div_start = 1'b0;
      div_num = '0;
      div_den = 40'd1;
      env_num = ({lvl_ff, 24'd0} - 48'(lvl_ff)) >> 23;
      case (state_ff)
         S_STEP: begin
            div_start = (ph_ff == PH_ATTACK) || (ph_ff == PH_DECAY) ||
                        (ph_ff == PH_RELEASE);
            case (ph_ff)
               PH_ATTACK: begin
                  div_num = {1'b0, KnobSquare, 23'd0};
                  div_den = 40'(KnobSquare) + 40'(StepsFull * asq_ff);
               end
               PH_DECAY: begin
                  div_num = {13'd0, KnobFull - cfg.sustain, 23'd0};
                  div_den = 40'(KnobFull) + 40'(StepsFull * cfg.decay);
               end
               default: begin
                  div_num = 48'({lvl_ff, 12'd0} - 36'(lvl_ff));
                  div_den = 40'(KnobFull) + 40'(StepsFull * cfg.release_k);
               end
            endcase
         end
         default: begin
         end
      endcase
   end

   // Sustain level 2^23 * s / 4095 is y + y / 4095 with y = s * 2^11, and
   // y / 4095 is exactly (y + y / 4096 + 1) / 4096 for this range of y.
   always_comb begin
      sus_y = {1'b0, cfg.sustain, 11'd0};
      sus_t = (sus_y + {12'd0, sus_y[23:12]} + 24'd1) >> 12;
      sus_calc = sus_y + sus_t;
   end

   // Envelope output over the selected divisor; six is a halving followed
   // by a reciprocal multiplication for the division by three.
   always_comb begin
      third_prod = 56'(env_num_ff[24:1]) * 56'(ThirdMagic);
      case (cfg.amp_sel)
         3'd0: env_q = env_num_ff[23:0];
         3'd1: env_q = env_num_ff[24:1];
         3'd2: env_q = {1'b0, third_prod[55:33]};
         3'd3: env_q = {3'd0, env_num_ff[24:4]};
         default: env_q = {4'd0, env_num_ff[24:5]};
      endcase
   end

   // Envelope phase update.
   always_comb begin
      lvl_s = 27'(lvl_ff);
      step_s = 27'(step_ff);
      sus_s = 27'(sus_ff);
      rel_step = (step_ff == 25'd0) ? 25'd1 : step_ff;
      nl = lvl_s;
      np = ph_ff;
      case (ph_ff)
         PH_IDLE: begin
            if (g_ff) np = PH_ATTACK;
         end
         PH_ATTACK: begin
            nl = lvl_s + step_s;
            if (nl >= 27'(LevelOne)) begin
               nl = 27'(LevelOne);
               np = PH_DECAY;
            end
            if (!g_ff) np = PH_RELEASE;
         end
         PH_DECAY: begin
            nl = lvl_s - step_s;
            if (nl <= sus_s) begin
               nl = sus_s;
               np = PH_SUSTAIN;
            end
            if (!g_ff) np = PH_RELEASE;
         end
         PH_SUSTAIN: begin
            nl = sus_s;
            if (!g_ff) np = PH_RELEASE;
         end
         default: begin
            nl = lvl_s - 27'(rel_step);
            if (nl <= 27'sd0) begin
               nl = 27'sd0;
               np = PH_IDLE;
            end
            if (g_ff) np = PH_ATTACK;
         end
      endcase
      if (nl < 27'sd0) nl = 27'sd0;
      if (nl > 27'sh0FFFFFF) nl = 27'sh0FFFFFF;
      mag = pay_ff[23] ? (25'h1000000 - 25'(pay_ff)) : 25'(pay_ff);
      prod_hi = prod_ff[47:23];
      if (!pay_ff[23]) begin
         smp = (prod_hi > 25'd8388607) ? 24'sh7FFFFF : 24'(prod_hi);
      end else begin
         smp = (prod_hi > 25'd8388608) ? 24'sh800000 : 24'(25'd0 - prod_hi);
      end
      pop = (state_ff == S_WAIT) && item_valid;
      rsp_valid = rsp_valid_ff;
      rsp_out_header = out_hdr_ff;
      rsp_shaped_sample = out_smp_ff;
      rsp_envelope_value = out_env_ff;
   end

   // Sequencer for one transaction from the queue.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_WAIT;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            level_ff[i] <= '0;
            phase_ff[i] <= PH_IDLE;
            gnow_ff[i] <= 1'b0;
            gbef_ff[i] <= 1'b0;
         end
      end else begin
         if (state_ff == S_OUT && (!rsp_valid_ff || rsp_ready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_WAIT: begin
               if (item_valid) begin
                  ch_ff <= ch_sel;
                  hdr_ff <= item.header;
                  pay_ff <= item.payload;
                  if (item.opcode == OpGate) begin
                     gnow_ff[ch_sel] <= (item.payload != 24'd0);
                  end else begin
                     g_ff <= gnow_ff[ch_sel];
                     gbef_ff[ch_sel] <= gnow_ff[ch_sel];
                     if (gnow_ff[ch_sel] && !gbef_ff[ch_sel]) begin
                        ph_ff <= PH_ATTACK;
                        lvl_ff <= '0;
                     end else begin
                        ph_ff <= phase_ff[ch_sel];
                        lvl_ff <= level_ff[ch_sel];
                     end
                     state_ff <= S_SUS;
                  end
               end
            end
            S_SUS: begin
               asq_ff <= cfg.attack * cfg.attack;
               sus_ff <= sus_calc;
               state_ff <= S_STEP;
            end
            S_STEP: begin
               step_ff <= '0;
               state_ff <= div_start ? S_STEPW : S_UPD;
            end
            S_STEPW: begin
               if (div_done) begin
                  step_ff <= div_quo[24:0];
                  state_ff <= S_UPD;
               end
            end
            S_UPD: begin
               lvl_ff <= nl[23:0];
               level_ff[ch_ff] <= nl[23:0];
               phase_ff[ch_ff] <= np;
               state_ff <= S_ENV;
            end
            S_ENV: begin
               prod_ff <= 49'(mag * lvl_ff);
               env_num_ff <= env_num[24:0];
               state_ff <= S_ENVW;
            end
            S_ENVW: begin
               env_ff <= env_q;
               state_ff <= S_OUT;
            end
            default: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  out_hdr_ff <= hdr_ff;
                  out_smp_ff <= smp;
                  out_env_ff <= env_ff;
                  state_ff <= S_WAIT;
               end
            end
         endcase
      end
   end

endmodule

### hdl/adsr_envelope_vca.sv
`timescale 1ns / 1ps
// Four-channel ADSR envelope generator with a built-in VCA.
// Frames enter on the req_ channel (valid/ready); frames with a bad header
// or channel are dropped at the input. Gate frames update the channel gate
// and give no result. Each audio frame gives one transaction on the rsp_
// channel: the shaped sample and the scaled envelope level.
// A two-entry queue parts the input classifier from the envelope sequencer,
// so frames are taken while the sequencer works or the output stalls.
// An audio frame in the attack, decay or release phase waits on the radix-2
// divider that forms the phase step (48 quotient bits); in the idle or sustain
// phase no step is divided. A gate frame is handled in the sequencer's wait
// state. The sequencer works on one audio frame at a time.
// The result stays in an output register until rsp_ready takes it; the
// sequencer waits for that register before loading the next result, and
// the queue then fills and lowers req_ready.
// Reset (synchronous) clears all levels to zero, phases to idle, gates
// off, configuration registers to zero, and empties the queue.
// Configuration is written through csr_ with no wait.
module adsr_envelope_vca
   import adsr_pkg::*;
#(
   parameter int NUM_CHANNELS = NumChannelsDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_opcode,
   input  logic [7:0]  req_frame_header,
   input  logic [23:0] req_frame_payload,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_header,
   output logic signed [23:0] rsp_shaped_sample,
   output logic [23:0] rsp_envelope_value,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [11:0] csr_write_data
);

   cfg_type  cfg_ff;
   logic     push, pop, q_full, q_valid;
   item_type push_item, head;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CsrAttack:    cfg_ff.attack <= csr_write_data;
            CsrDecay:     cfg_ff.decay <= csr_write_data;
            CsrSustain:   cfg_ff.sustain <= csr_write_data;
            CsrRelease:   cfg_ff.release_k <= csr_write_data;
            CsrAmplitude: cfg_ff.amp_sel <= csr_write_data[2:0];
            default: begin
            end
         endcase
      end
   end

   adsr_front #(.NUM_CHANNELS(NUM_CHANNELS)) u_front (
      .req_valid(req_valid), .queue_full(q_full), .req_opcode(req_opcode),
      .req_frame_header(req_frame_header), .req_frame_payload(req_frame_payload),
      .req_ready(req_ready), .push(push), .push_item(push_item)
   );

   adsr_queue u_queue (
      .clock(clock), .reset(reset), .push(push), .push_item(push_item),
      .pop(pop), .full(q_full), .not_empty(q_valid), .head(head)
   );

   adsr_back #(.NUM_CHANNELS(NUM_CHANNELS)) u_back (
      .clock(clock), .reset(reset), .cfg(cfg_ff), .item_valid(q_valid),
      .item(head), .pop(pop), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_out_header(rsp_out_header), .rsp_shaped_sample(rsp_shaped_sample),
      .rsp_envelope_value(rsp_envelope_value)
   );

endmodule

### dv/adsr_envelope_checker.sv
`timescale 1ns / 1ps
module adsr_envelope_checker
   import adsr_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic               req_opcode,
   input  logic [7:0]         req_frame_header,
   input  logic [23:0]        req_frame_payload,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic [7:0]         rsp_out_header,
   input  logic signed [23:0] rsp_shaped_sample,
   input  logic [23:0]        rsp_envelope_value,
   input  logic               csr_write_enable,
   input  logic [2:0]         csr_index,
   input  logic [11:0]        csr_write_data,
   output int                 mismatch_count,
   output int                 results_pending
);

   typedef enum logic [2:0] {
      PhIdle, PhAttack, PhDecay, PhSustain, PhRelease
   } env_phase_type;

   typedef struct {
      logic [7:0]  header;
      logic [23:0] shaped;
      logic [23:0] env_value;
   } shaped_frame_type;

   localparam longint QOne = 64'h800000;
   localparam longint Knob = 4095;
   localparam longint Steps = 48000;

   shaped_frame_type shaped_queue[$];
   cfg_type          knobs;
   longint           level_q[NumChannelsDefault];
   env_phase_type    phase_q[NumChannelsDefault];
   logic             gate_on[NumChannelsDefault];
   logic             gate_prev[NumChannelsDefault];

   assign results_pending = shaped_queue.size();

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   // Works out the result of one frame, if it gives one, and advances the envelope.
   task automatic shape_frame(input logic op, input logic [7:0] hdr, input logic [23:0] pay);
      int               ch;
      longint           lvl, sus, kk, att, dec, rel, mag, prod, shaped, div;
      shaped_frame_type sf;
      ch = hdr[6:4];
      if (hdr[3:0] != 4'hF || ch >= NumChannelsDefault) return;
      if (op == OpGate) begin
         gate_on[ch] = (pay != 0);
         return;
      end
      if (gate_on[ch] && !gate_prev[ch]) begin
         phase_q[ch] = PhAttack;
         level_q[ch] = 0;
      end
      gate_prev[ch] = gate_on[ch];

      lvl = level_q[ch];
      sus = (QOne * longint'(knobs.sustain)) / Knob;
      kk = Knob * Knob;
      att = (QOne * kk) / (kk + Steps * longint'(knobs.attack) * longint'(knobs.attack));
      dec = (QOne * (Knob - longint'(knobs.sustain))) / (Knob + Steps * longint'(knobs.decay));
      rel = (lvl * Knob) / (Knob + Steps * longint'(knobs.release_k));
      if (rel < 1) rel = 1;
      case (phase_q[ch])
         PhIdle: begin
            if (gate_on[ch]) phase_q[ch] = PhAttack;
         end
         PhAttack: begin
            lvl += att;
            if (lvl >= QOne) begin
               lvl = QOne;
               phase_q[ch] = PhDecay;
            end
            if (!gate_on[ch]) phase_q[ch] = PhRelease;
         end
         PhDecay: begin
            lvl -= dec;
            if (lvl <= sus) begin
               lvl = sus;
               phase_q[ch] = PhSustain;
            end
            if (!gate_on[ch]) phase_q[ch] = PhRelease;
         end
         PhSustain: begin
            lvl = sus;
            if (!gate_on[ch]) phase_q[ch] = PhRelease;
         end
         default: begin
            lvl -= rel;
            if (lvl <= 0) begin
               lvl = 0;
               phase_q[ch] = PhIdle;
            end
            if (gate_on[ch]) phase_q[ch] = PhAttack;
         end
      endcase
      if (lvl < 0) lvl = 0;
      if (lvl > 64'hFFFFFF) lvl = 64'hFFFFFF;
      level_q[ch] = lvl;

      // Sign and magnitude product, truncated toward zero.
      if (pay[23]) begin
         mag = 64'h1000000 - longint'(pay);
         prod = (mag * lvl) >>> 23;
         shaped = -prod;
      end else begin
         prod = (longint'(pay) * lvl) >>> 23;
         shaped = prod;
      end
      if (shaped > 8388607) shaped = 8388607;
      if (shaped < -8388608) shaped = -8388608;

      case (knobs.amp_sel)
         3'd0: div = 1;
         3'd1: div = 2;
         3'd2: div = 6;
         3'd3: div = 16;
         default: div = 32;
      endcase
      sf.header = hdr;
      sf.shaped = shaped[23:0];
      sf.env_value = 24'((lvl * 64'hFFFFFF) / (QOne * div));
      shaped_queue.push_back(sf);
   endtask

   // Track register writes, predict each input transaction, check each result.
   always @(posedge clock) begin
      shaped_frame_type want;
      if (reset) begin
         knobs = '0;
         shaped_queue.delete();
         for (int i = 0; i < NumChannelsDefault; i++) begin
            level_q[i] = 0;
            phase_q[i] = PhIdle;
            gate_on[i] = 1'b0;
            gate_prev[i] = 1'b0;
         end
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CsrAttack: knobs.attack = csr_write_data;
               CsrDecay: knobs.decay = csr_write_data;
               CsrSustain: knobs.sustain = csr_write_data;
               CsrRelease: knobs.release_k = csr_write_data;
               CsrAmplitude: knobs.amp_sel = csr_write_data[2:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (shaped_queue.size() == 0) begin
               report_mismatch("unexpected result header", rsp_out_header, 0);
            end else begin
               want = shaped_queue.pop_front();
               if (rsp_out_header !== want.header)
                  report_mismatch("out_header", rsp_out_header, want.header);
               if (rsp_shaped_sample !== want.shaped)
                  report_mismatch("shaped_sample", rsp_shaped_sample, want.shaped);
               if (rsp_envelope_value !== want.env_value)
                  report_mismatch("envelope_value", rsp_envelope_value, want.env_value);
            end
         end
         if (req_valid && req_ready)
            shape_frame(req_opcode, req_frame_header, req_frame_payload);
      end
   end

   initial mismatch_count = 0;

endmodule

### dv/adsr_envelope_vca_tb.sv
`timescale 1ns / 1ps
module adsr_envelope_vca_tb
   import adsr_pkg::*;
();

   localparam int StallLimit = 20000;
   localparam int DrainCycles = 300;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic               req_opcode = 1'b0;
   logic [7:0]         req_frame_header = '0;
   logic [23:0]        req_frame_payload = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [7:0]         rsp_out_header;
   logic signed [23:0] rsp_shaped_sample;
   logic [23:0]        rsp_envelope_value;
   logic               csr_write_enable = 1'b0;
   logic [2:0]         csr_index = '0;
   logic [11:0]        csr_write_data = '0;
   int                 mismatch_count;
   int                 results_pending;
   int                 send_idle_pct = 0;
   int                 recv_idle_pct = 0;
   int                 quiet_cycles = 0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   adsr_envelope_vca u_top (.*);

   adsr_envelope_checker u_checker (.*);

   // Result side: take results with the current stall rate.
   always @(posedge clock) rsp_ready <= ($urandom_range(99) >= recv_idle_pct);

   // Stop the run if no transaction moves for too long.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
         $display("Verification failed");
         $finish;
      end
   end

   task automatic write_reg(input logic [2:0] idx, input logic [11:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_frame(input logic op, input logic [7:0] hdr, input logic [23:0] pay);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_frame_header <= hdr;
      req_frame_payload <= pay;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Hold the input until every result is back and the sequencer is quiet.
   task automatic drain_block();
      req_valid <= 1'b0;
      @(posedge clock);
      while (results_pending != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   function automatic logic [11:0] pick_knob();
      case ($urandom_range(9))
         0: return 12'd0;
         1: return 12'd4095;
         2: return 12'($urandom_range(0, 4095));
         default: return 12'($urandom_range(0, 40));
      endcase
   endfunction

   // Mostly well-formed frames on valid channels; some noise headers.
   task automatic send_random_frame();
      logic [7:0]  hdr;
      logic [23:0] pay;
      logic        op;
      if ($urandom_range(99) < 10) begin
         hdr = 8'($urandom);
         op = 1'($urandom);
         pay = 24'($urandom);
      end else begin
         hdr = {1'($urandom), 3'($urandom_range(0, 3)), 4'hF};
         op = ($urandom_range(99) < 15) ? OpGate : OpAudio;
         case ($urandom_range(9))
            0: pay = 24'h000000;
            1: pay = 24'h7FFFFF;
            2: pay = 24'h800000;
            3: pay = 24'hFFFFFF;
            default: pay = 24'($urandom);
         endcase
         if (op == OpGate && $urandom_range(1)) pay = '0;
      end
      send_frame(op, hdr, pay);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part with every knob at zero: instant attack and decay.
      write_reg(CsrAttack, 12'd0);
      write_reg(CsrDecay, 12'd0);
      write_reg(CsrSustain, 12'd0);
      write_reg(CsrRelease, 12'd0);
      write_reg(CsrAmplitude, 12'd0);
      send_frame(OpAudio, 8'h3F, 24'h123456);
      send_frame(OpGate, 8'h0F, 24'h000001);
      send_frame(OpAudio, 8'h0F, 24'h7FFFFF);
      send_frame(OpAudio, 8'h0F, 24'h800000);
      send_frame(OpAudio, 8'h0F, 24'h000000);
      send_frame(OpAudio, 8'h0F, 24'hFFFFFF);
      send_frame(OpGate, 8'h9F, 24'hFFFFFF);
      send_frame(OpAudio, 8'h9F, 24'h800000);
      send_frame(OpAudio, 8'h1F, 24'h7FFFFF);
      send_frame(OpAudio, 8'h0E, 24'h7FFFFF);
      send_frame(OpGate, 8'h5F, 24'h000001);
      send_frame(OpAudio, 8'hFF, 24'h7FFFFF);
      send_frame(OpAudio, 8'hF0, 24'h000001);
      send_frame(OpGate, 8'h0F, 24'h000000);
      send_frame(OpAudio, 8'h0F, 24'h400000);
      send_frame(OpAudio, 8'h0F, 24'h400000);
      send_frame(OpGate, 8'h2F, 24'h800000);
      send_frame(OpAudio, 8'hAF, 24'hC00000);
      send_frame(OpAudio, 8'h2F, 24'h3FFFFF);
      drain_block();

      // Random phases: the receiver idles more at first, then the sender, then neither.
      for (int ph = 0; ph < 8; ph++) begin
         send_idle_pct = (ph < 3) ? 10 : (ph < 6) ? 46 : 0;
         recv_idle_pct = (ph < 3) ? 46 : (ph < 6) ? 10 : 0;
         if (ph == 0) begin
            write_reg(CsrAttack, 12'd4095);
            write_reg(CsrDecay, 12'd4095);
            write_reg(CsrSustain, 12'd4095);
            write_reg(CsrRelease, 12'd4095);
            write_reg(CsrAmplitude, 12'd4);
         end else begin
            write_reg(CsrAttack, pick_knob());
            write_reg(CsrDecay, pick_knob());
            write_reg(CsrSustain, pick_knob());
            write_reg(CsrRelease, pick_knob());
            write_reg(CsrAmplitude, 12'($urandom_range(0, 7)));
            if (ph == 4) write_reg(CsrAmplitude + 3'd1, 12'hFFF);
         end
         for (int n = 0; n < 250; n++) send_random_frame();
         drain_block();
      end

      if (mismatch_count == 0 && results_pending == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end

endmodule

### adsr_envelope_vca.f
hdl/adsr_pkg.sv
hdl/adsr_front.sv
hdl/adsr_queue.sv
hdl/adsr_div.sv
hdl/adsr_back.sv
hdl/adsr_envelope_vca.sv
dv/adsr_envelope_checker.sv
dv/adsr_envelope_vca_tb.sv
